>>> src/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg: shared definitions for the page frame bitmap allocator
// Field widths, request codes and the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int WORD_W         = 32;
  localparam int WORD_SH        = 5;
  localparam int REQ_TYPE_W     = 3;
  localparam int FRAME_NUM_W    = 20;
  localparam int RUN_LEN_W      = 11;
  localparam int CNT_W          = 11;
  localparam int FOUND_FRAME_W  = 10;
  localparam int NWORDS_W       = CNT_W - WORD_SH + 1;

  localparam logic [CNT_W-1:0] FRAMES_RESET = 11'd1024;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_MARK_USED = 3'd0,
    REQ_MARK_FREE = 3'd1,
    REQ_TEST      = 3'd2,
    REQ_FIND_FREE = 3'd3,
    REQ_FIND_RUN  = 3'd4
  } req_type_t;

  typedef struct packed {
    logic req_load;
    logic idx_clr;
    logic idx_inc;
    logic mem_rd_frame;
    logic mem_rd_idx;
    logic mem_wr_zero;
    logic mem_wr_frame;
    logic scan_init;
    logic out_load;
  } pfba_cmd_t;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic                  in_range;
    logic                  count_zero;
    logic                  len_zero;
    logic                  clear_last;
    logic                  scan_end;
    logic                  eval_busy;
    logic                  hit;
  } pfba_stat_t;

endpackage

>>> src/pfba_dpath.sv
// ----------------------------------------------------------------------------
// pfba_dpath: bitmap memory and search datapath
// Holds the frame count register, the captured request, the bitmap words and
// the word-wide run search that carries the free run across word borders.
// ----------------------------------------------------------------------------
module pfba_dpath #(
  parameter int MAX_FRAMES = pfba_pkg::MAX_FRAMES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [pfba_pkg::CNT_W-1:0]           cfg_wr_data,
  input  logic [pfba_pkg::REQ_TYPE_W-1:0]      in_type,
  input  logic [pfba_pkg::FRAME_NUM_W-1:0]     in_frame,
  input  logic [pfba_pkg::RUN_LEN_W-1:0]       in_len,
  input  pfba_pkg::pfba_cmd_t                  cmd,
  output pfba_pkg::pfba_stat_t                 stat,
  output logic                                 out_frame_used,
  output logic                                 out_found,
  output logic [pfba_pkg::FOUND_FRAME_W-1:0]   out_found_frame
);

  localparam int WW    = pfba_pkg::WORD_W;
  localparam int SH    = pfba_pkg::WORD_SH;
  localparam int CW    = pfba_pkg::CNT_W;
  localparam int LW    = pfba_pkg::RUN_LEN_W;
  localparam int WORDS = (MAX_FRAMES + WW - 1) / WW;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW    = (AW + 1 > pfba_pkg::NWORDS_W) ? AW + 1 : pfba_pkg::NWORDS_W;
  localparam int BW    = IW + SH;
  localparam logic [WW-1:0] ONES = '1;

  logic [WW-1:0] bitmap_mem [WORDS];

  logic [CW-1:0]                         frames_in_use_r;
  logic [pfba_pkg::REQ_TYPE_W-1:0]       req_type_r;
  logic [pfba_pkg::FRAME_NUM_W-1:0]      frame_r;
  logic [LW-1:0]                         len_r;
  logic [IW-1:0]                         idx_r;
  logic                                  eval_vld_r;
  logic [IW-1:0]                         eval_idx_r;
  logic [WW-1:0]                         rdata_r;
  logic [CW-1:0]                         carry_r;
  logic                                  hit_r;
  logic [pfba_pkg::FOUND_FRAME_W-1:0]    start_r;
  logic                                  frame_used_r;
  logic                                  found_r;
  logic [pfba_pkg::FOUND_FRAME_W-1:0]    found_frame_r;

  logic [CW-1:0]                         count;
  logic [CW:0]                           cnt_up;
  logic [pfba_pkg::NWORDS_W-1:0]         nwords;
  logic                                  in_range;
  logic [AW-1:0]                         frame_word;
  logic [SH-1:0]                         bitpos;
  logic [LW-1:0]                         eff_len;
  logic                                  len_zero;
  logic                                  count_zero;
  logic                                  is_search;
  logic [WW-1:0]                         bitmask;
  logic [WW-1:0]                         modified;
  logic [AW-1:0]                         wr_addr;
  logic [AW-1:0]                         rd_addr;
  logic [WW-1:0]                         wr_data;

  logic [BW-1:0]                         base;
  logic [BW-1:0]                         rem;
  logic [WW-1:0]                         free;
  logic [WW-1:0]                         ge;
  logic signed [LW:0]                    dif;
  logic [WW-1:0]                         hit_vec;
  logic                                  hit_any;
  logic [SH-1:0]                         hit_pos;
  logic [BW-1:0]                         start_w;
  logic [SH:0]                           top_run;
  logic [CW:0]                           carry_sum;
  logic [CW-1:0]                         carry_nxt;
  logic                                  win;

  assign count = (int'(frames_in_use_r) > MAX_FRAMES) ? CW'(MAX_FRAMES) : frames_in_use_r;
  assign cnt_up = {1'b0, count} + (CW + 1)'(WW - 1);
  assign nwords = cnt_up[CW:SH];
  assign count_zero = (count == '0);
  assign in_range = (frame_r < pfba_pkg::FRAME_NUM_W'(count));
  assign frame_word = frame_r[SH +: AW];
  assign bitpos = frame_r[SH-1:0];
  assign eff_len = (req_type_r == pfba_pkg::REQ_FIND_FREE) ? LW'(1) : len_r;
  assign len_zero = (eff_len == '0);
  assign is_search = (req_type_r == pfba_pkg::REQ_FIND_FREE) ||
                     (req_type_r == pfba_pkg::REQ_FIND_RUN);

  assign bitmask = WW'(1) << bitpos;
  assign modified = (req_type_r == pfba_pkg::REQ_MARK_USED) ? (rdata_r | bitmask)
                                                            : (rdata_r & ~bitmask);
  assign wr_addr = cmd.mem_wr_zero ? idx_r[AW-1:0] : frame_word;
  assign wr_data = cmd.mem_wr_zero ? '0 : modified;
  assign rd_addr = cmd.mem_rd_idx ? idx_r[AW-1:0] : frame_word;

  always_comb begin
    base = BW'(eval_idx_r) << SH;
    rem = BW'(count) - base;
    for (int i = 0; i < WW; i++) begin
      free[i] = !rdata_r[i] && (rem > BW'(i));
      ge[i] = (eff_len > LW'(i));
    end
    dif = $signed({1'b0, eff_len}) - $signed({1'b0, carry_r});
    for (int p = 0; p < WW; p++) begin
      win = 1'b1;
      for (int j = 0; j <= p; j++) begin
        if (ge[p-j] && !free[j]) begin
          win = 1'b0;
        end
      end
      hit_vec[p] = win && (dif <= $signed((LW + 1)'(p + 1)));
    end
    hit_any = |hit_vec;
    hit_pos = '0;
    for (int p = WW - 1; p >= 0; p--) begin
      if (hit_vec[p]) begin
        hit_pos = SH'(p);
      end
    end
    start_w = base + BW'(hit_pos) + BW'(1) - BW'(eff_len);
    top_run = '0;
    for (int n = 1; n <= WW; n++) begin
      if ((free | (ONES >> n)) == ONES) begin
        top_run = (SH + 1)'(n);
      end
    end
    carry_sum = {1'b0, carry_r} + (CW + 1)'(WW);
    if (&free) begin
      carry_nxt = carry_sum[CW] ? '1 : carry_sum[CW-1:0];
    end else begin
      carry_nxt = CW'(top_run);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr_zero || cmd.mem_wr_frame) begin
      bitmap_mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd_frame || cmd.mem_rd_idx) begin
      rdata_r <= bitmap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= pfba_pkg::FRAMES_RESET;
      idx_r <= '0;
      eval_vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frames_in_use_r <= cfg_wr_data;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IW'(1);
      end
      eval_vld_r <= cmd.mem_rd_idx;
      if (cmd.scan_init) begin
        hit_r <= 1'b0;
      end else if (eval_vld_r && !hit_r && hit_any) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_type_r <= in_type;
      frame_r <= in_frame;
      len_r <= in_len;
    end
    if (cmd.mem_rd_idx) begin
      eval_idx_r <= idx_r;
    end
    if (cmd.scan_init) begin
      carry_r <= '0;
    end else if (eval_vld_r && !hit_r) begin
      carry_r <= carry_nxt;
      if (hit_any) begin
        start_r <= start_w[pfba_pkg::FOUND_FRAME_W-1:0];
      end
    end
    if (cmd.out_load) begin
      frame_used_r <= (req_type_r == pfba_pkg::REQ_TEST) && in_range && rdata_r[bitpos];
      found_r <= is_search && !count_zero && (len_zero || hit_r);
      found_frame_r <= (is_search && !count_zero && !len_zero && hit_r) ? start_r : '0;
    end
  end

  assign stat.req_type = req_type_r;
  assign stat.in_range = in_range;
  assign stat.count_zero = count_zero;
  assign stat.len_zero = len_zero;
  assign stat.clear_last = (idx_r == IW'(WORDS - 1));
  assign stat.scan_end = (idx_r >= IW'(nwords));
  assign stat.eval_busy = eval_vld_r;
  assign stat.hit = hit_r;

  assign out_frame_used = frame_used_r;
  assign out_found = found_r;
  assign out_found_frame = found_frame_r;

endmodule

>>> src/pfba_ctrl.sv
// ----------------------------------------------------------------------------
// pfba_ctrl: request sequencer for the page frame bitmap allocator
// Clears the bitmap after reset, then decodes each request and steps the
// datapath through a word access or a word-by-word search.
// ----------------------------------------------------------------------------
module pfba_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  pfba_pkg::pfba_stat_t  stat,
  output pfba_pkg::pfba_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_CLEAR: begin
        cmd.mem_wr_zero = 1'b1;
        if (stat.clear_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.req_type inside {pfba_pkg::REQ_MARK_USED, pfba_pkg::REQ_MARK_FREE,
                                  pfba_pkg::REQ_TEST}) begin
          if (stat.in_range) begin
            cmd.mem_rd_frame = 1'b1;
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.req_type inside {pfba_pkg::REQ_FIND_FREE,
                                           pfba_pkg::REQ_FIND_RUN}) begin
          if (!stat.count_zero && !stat.len_zero) begin
            cmd.scan_init = 1'b1;
            cmd.idx_clr = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        if (stat.req_type != pfba_pkg::REQ_TEST) begin
          cmd.mem_wr_frame = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (stat.hit || (stat.scan_end && !stat.eval_busy)) begin
          state_nxt = S_DONE;
        end else if (!stat.scan_end) begin
          cmd.mem_rd_idx = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

>>> src/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator: used/free bitmap over physical page frames
//
//   Channel  Direction  Signals                         Contents
//   in       slave      in_tvalid/in_tready/in_tdata    request beat
//                       in_tuser
//   out      master     out_tvalid/out_tready/out_tdata result beat
//   cfg      write      cfg_wr_en/cfg_wr_data           frame count register
//
// Mark and test requests pass through the DECODE, READ and DONE states from accept
// to result beat; a frame out of range skips READ.
// Searches read one bitmap word per cycle from the single memory read port and
// stop at the first hit or once the words in use are read.
// After reset a clearing pass writes zero to every bitmap word, one per cycle,
// with in_tready low.
// A new request is accepted while an earlier result beat still waits.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator #(
  parameter int MAX_FRAMES = pfba_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,    // frame_number, run_length, zero pad
  input  logic [pfba_pkg::REQ_TYPE_W-1:0] in_tuser,   // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,   // frame_used, found, found_frame, zero pad
  input  logic                           cfg_wr_en,
  input  logic [pfba_pkg::CNT_W-1:0]     cfg_wr_data
);

  localparam int FNW = pfba_pkg::FRAME_NUM_W;
  localparam int RLW = pfba_pkg::RUN_LEN_W;
  localparam int FFW = pfba_pkg::FOUND_FRAME_W;

  pfba_pkg::pfba_cmd_t  cmd;
  pfba_pkg::pfba_stat_t stat;
  logic                 frame_used;
  logic                 found;
  logic [FFW-1:0]       found_frame;

  pfba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pfba_dpath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_type         (in_tuser),
    .in_frame        (in_tdata[FNW-1:0]),
    .in_len          (in_tdata[FNW +: RLW]),
    .cmd             (cmd),
    .stat            (stat),
    .out_frame_used  (frame_used),
    .out_found       (found),
    .out_found_frame (found_frame)
  );

  assign out_tdata = 16'({found_frame, found, frame_used});

  a_no_used_and_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("test and search results both set in one beat");

  a_frame_zero_when_missed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[1]) |-> (out_tdata[11:2] == '0))
    else $error("found_frame nonzero without a find");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while the previous one is in work");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: page frame bitmap allocator
// Drives mark, test and search requests through the request stream under
// several frame counts and idle patterns. A model of the used/free bitmap
// predicts each result beat, and every received beat is checked against it.
// ----------------------------------------------------------------------------
module testbench;

  localparam int REQ_W = pfba_pkg::REQ_TYPE_W;
  localparam int FNW   = pfba_pkg::FRAME_NUM_W;
  localparam int RLW   = pfba_pkg::RUN_LEN_W;
  localparam int FFW   = pfba_pkg::FOUND_FRAME_W;
  localparam int CW    = pfba_pkg::CNT_W;
  localparam int MAXF  = pfba_pkg::MAX_FRAMES_DEF;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = pfba_pkg::REQ_FIND_RUN + 3'd1;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = '1;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 53;

  typedef struct {
    logic           frame_used;
    logic           found;
    logic [FFW-1:0] found_frame;
  } reply_t;

  class frame_ledger;
    bit [MAXF-1:0]   used_map;
    logic [CW-1:0]   frame_limit;
    reply_t          replies[$];
    int              errors;

    function new();
      used_map    = '0;
      frame_limit = pfba_pkg::FRAMES_RESET;
      errors      = 0;
    endfunction

    function int managed_frames();
      return (frame_limit > MAXF) ? MAXF : int'(frame_limit);
    endfunction

    function bit find_free_run(int len, output int start);
      int count;
      int run;
      count = managed_frames();
      start = 0;
      run   = 0;
      if (count == 0) return 0;
      if (len == 0) return 1;
      for (int f = 0; f < count; f++) begin
        run = used_map[f] ? 0 : run + 1;
        if (run >= len) begin
          start = f + 1 - len;
          return 1;
        end
      end
      return 0;
    endfunction

    function void record_request(logic [REQ_W-1:0] kind,
                                 logic [FNW-1:0] frame,
                                 logic [RLW-1:0] len);
      reply_t r;
      int     start;
      bit     in_range;
      r        = '{frame_used: 1'b0, found: 1'b0, found_frame: '0};
      in_range = int'(frame) < managed_frames();
      case (kind)
        pfba_pkg::REQ_MARK_USED: if (in_range) used_map[frame] = 1'b1;
        pfba_pkg::REQ_MARK_FREE: if (in_range) used_map[frame] = 1'b0;
        pfba_pkg::REQ_TEST:      r.frame_used = in_range && used_map[frame];
        pfba_pkg::REQ_FIND_FREE, pfba_pkg::REQ_FIND_RUN: begin
          if (find_free_run((kind == pfba_pkg::REQ_FIND_FREE) ? 1 : int'(len), start)) begin
            r.found       = 1'b1;
            r.found_frame = start[FFW-1:0];
          end
        end
        default: ;
      endcase
      replies.push_back(r);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [15:0] beat);
      reply_t want;
      if (replies.size() == 0) begin
        $display("%0t: result beat %h arrived with no request pending", $time, beat);
        errors++;
        return;
      end
      want = replies.pop_front();
      if ($isunknown(beat)) begin
        $display("%0t: result beat, expected known bits, actual %h", $time, beat);
        errors++;
        return;
      end
      compare("frame_used", want.frame_used, beat[0]);
      compare("found", want.found, beat[1]);
      compare("found_frame", want.found_frame, beat[11:2]);
      compare("pad", 0, beat[15:12]);
    endfunction
  endclass

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata    = '0;
  logic [REQ_W-1:0]  in_tuser    = pfba_pkg::REQ_MARK_USED;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [15:0]       out_tdata;
  logic              cfg_wr_en   = 1'b0;
  logic [CW-1:0]     cfg_wr_data = '0;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        rx_hold     = 1'b0;
  int          quiet_cycles = 0;
  frame_ledger board = new();

  page_frame_bitmap_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        board.record_request(in_tuser, in_tdata[19:0], in_tdata[30:20]);
      end
      if (out_tvalid && out_tready) begin
        board.check_reply(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [FNW-1:0] frame,
                              input logic [RLW-1:0] len);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, len, frame};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [FNW-1:0] pick_frame(int count);
    int r;
    r = $urandom_range(99);
    if (count > 0 && r < 45) return FNW'($urandom_range((count < 48) ? count - 1 : 47));
    if (count > 0 && r < 85) return FNW'($urandom_range(count - 1));
    if (r < 93) return FNW'(count + $urandom_range(2));
    return FNW'($urandom);
  endfunction

  function automatic logic [RLW-1:0] pick_run(int count);
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 65) return RLW'($urandom_range(1, 6));
    if (r < 80) return RLW'($urandom_range(1, (count > 0) ? count : 1));
    if (r < 92) return RLW'(count + $urandom_range(2) - 1);
    return RLW'($urandom);
  endfunction

  task automatic send_random();
    int               r;
    int               count;
    logic [REQ_W-1:0] kind;
    r     = $urandom_range(99);
    count = board.managed_frames();
    if (r < 35) kind = pfba_pkg::REQ_MARK_USED;
    else if (r < 52) kind = pfba_pkg::REQ_MARK_FREE;
    else if (r < 67) kind = pfba_pkg::REQ_TEST;
    else if (r < 79) kind = pfba_pkg::REQ_FIND_FREE;
    else if (r < 95) kind = pfba_pkg::REQ_FIND_RUN;
    else kind = REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
    send_request(kind, pick_frame(count), pick_run(count));
  endtask

  task automatic wait_all_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_limit(input logic [CW-1:0] value);
    wait_all_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.frame_limit = value;
  endtask

  initial begin
    logic [CW-1:0] limits[9];
    limits = '{11'd0, 11'd2047, 11'd37, 11'd1, 11'd64, 11'd300, 11'd1024, 11'd32, 11'd100};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(pfba_pkg::REQ_MARK_USED, 20'd0, '0);
    send_request(pfba_pkg::REQ_MARK_USED, 20'd1023, '0);
    send_request(pfba_pkg::REQ_MARK_USED, 20'd1024, '0);
    send_request(pfba_pkg::REQ_MARK_USED, 20'hFFFFF, '1);
    send_request(pfba_pkg::REQ_TEST, 20'd0, '0);
    send_request(pfba_pkg::REQ_TEST, 20'd1023, '0);
    send_request(pfba_pkg::REQ_TEST, 20'd1024, '0);
    send_request(pfba_pkg::REQ_TEST, 20'hFFFFF, '0);
    send_request(pfba_pkg::REQ_TEST, 20'd5, '0);
    send_request(pfba_pkg::REQ_FIND_FREE, 20'd0, '0);
    send_request(pfba_pkg::REQ_FIND_RUN, 20'd0, 11'd0);
    send_request(pfba_pkg::REQ_FIND_RUN, 20'd0, 11'd1022);
    send_request(pfba_pkg::REQ_FIND_RUN, 20'd0, 11'd1023);
    send_request(pfba_pkg::REQ_FIND_RUN, 20'd0, 11'd2047);
    send_request(pfba_pkg::REQ_MARK_FREE, 20'd0, '0);
    send_request(pfba_pkg::REQ_FIND_RUN, 20'd0, 11'd1023);
    send_request(pfba_pkg::REQ_FIND_RUN, 20'd0, 11'd1024);
    send_request(pfba_pkg::REQ_MARK_FREE, 20'd1023, '0);
    send_request(pfba_pkg::REQ_FIND_RUN, 20'd0, 11'd1024);
    send_request(REQ_UNKNOWN_FIRST, 20'hFFFFF, '1);
    send_request(REQ_UNKNOWN_LAST, 20'd3, 11'd3);
    send_request(pfba_pkg::REQ_FIND_FREE, 20'hFFFFF, '1);

    for (int p = 0; p < 9; p++) begin
      write_frame_limit(limits[p]);
      if (p < 3) begin
        tx_idle_pct = 38;
        rx_idle_pct <= 47;
      end else if (p < 6) begin
        tx_idle_pct = 47;
        rx_idle_pct <= 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (p == 6) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
          repeat (PHASE_ITEMS / 2) send_random();
        join
        wait_all_replies();
        repeat (PHASE_ITEMS - PHASE_ITEMS / 2) send_random();
      end else begin
        repeat (PHASE_ITEMS) send_random();
      end
    end

    wait_all_replies();
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
